[hdl/refcounted_fifo_tag_cache_unit_defines.svh]
// Assertion macros used by the RTL of the tag cache.
`ifndef REFCOUNTED_FIFO_TAG_CACHE_UNIT_DEFINES_SVH
`define REFCOUNTED_FIFO_TAG_CACHE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Concurrent check, disabled while reset is asserted.
`define RFTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check that also holds during reset.
`define RFTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFTC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/refc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refc_pkg
// Shared types and codes of the reference-counted FIFO tag cache.
// ----------------------------------------------------------------------------
package refc_pkg;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned HANDLE_W = 7;
    localparam int unsigned OFFSET_W = 64;
    localparam int unsigned REFS_W   = 16;
    localparam int unsigned LIMIT_W  = 7;

    localparam logic [LIMIT_W-1:0] MAX_CACHED_RESET = 7'd50;
    localparam logic [REFS_W-1:0]  REFS_MAX         = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNREF  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_HDL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IS_CACHED = 3'd4;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_ALLOC  = 12'b0000_0000_0010,
        S_OFS    = 12'b0000_0000_0100,
        S_LOOK   = 12'b0000_0000_1000,
        S_INC    = 12'b0000_0001_0000,
        S_DUP    = 12'b0000_0010_0000,
        S_EVICT  = 12'b0000_0100_0000,
        S_DEC    = 12'b0000_1000_0000,
        S_APPEND = 12'b0001_0000_0000,
        S_RMSCAN = 12'b0010_0000_0000,
        S_SHIFT  = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

endpackage

[hdl/refc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refc_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module refc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

[hdl/refcounted_fifo_tag_cache_unit.sv]
`timescale 1ns / 1ps
`include "refcounted_fifo_tag_cache_unit_defines.svh"
// ----------------------------------------------------------------------------
// refcounted_fifo_tag_cache_unit
// Pool of reference-counted records tagged by table offset, with a
// FIFO-ordered fully associative cache of record handles.
//
// Usage: drive i_mode/i_offset/i_handle/i_handle_null and pulse start while
// busy is low; the command is taken at that edge. Exactly one result comes
// back as a one-cycle o_valid strobe with o_status and the handle fields;
// busy drops the cycle after. The receiver cannot stall, so results are
// never held. One command is in flight at a time.
// Alloc examines one live bit per cycle, from index 0 up to the lowest free
// record. Find and commit scan the ring through the ring RAM and offset
// RAM, one entry per cycle; commit first reads the record's own offset,
// and an eviction adds the evict and decrement steps before the append.
// A record freed while cached is taken out of the ring by a second pass
// that reads and rewrites the ring entries behind it. Unref otherwise
// reads and decrements the record's count.
// i_cfg_wr_en writes max_cached (0 acts as 1, above CACHE_SLOTS as
// CACHE_SLOTS); write it only while busy is low.
// Reset (synchronous, active low) empties the pool and cache and sets
// max_cached to 50; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_fifo_tag_cache_unit
    import refc_pkg::*;
#(
    parameter int unsigned POOL_ENTRIES = 128,
    parameter int unsigned CACHE_SLOTS  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_handle_null,
    input  logic                i_cfg_wr_en,
    input  logic [LIMIT_W-1:0]  i_cfg_wr_data,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_result_handle,
    output logic                o_evicted_valid,
    output logic [HANDLE_W-1:0] o_evicted_handle,
    output logic                o_freed_valid,
    output logic [HANDLE_W-1:0] o_freed_handle
);

    localparam int unsigned PW = $clog2(POOL_ENTRIES);
    localparam int unsigned SW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int unsigned CW = $clog2(CACHE_SLOTS + 1);

    t_state              r_state, n_state;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [OFFSET_W-1:0] r_tag, n_tag;
    logic [PW-1:0]       r_h, n_h;
    logic [PW-1:0]       r_tgt, n_tgt;
    logic [PW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_wpos, n_wpos;
    logic [CW-1:0]       r_s1pos, n_s1pos;
    logic                r_s1v, n_s1v;
    logic                r_s2v, n_s2v;
    logic [PW-1:0]       r_s2h, n_s2h;
    logic                r_ret_append, n_ret_append;
    logic [SW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [LIMIT_W-1:0]  r_max_cached;
    logic [POOL_ENTRIES-1:0] r_live, n_live;
    logic [POOL_ENTRIES-1:0] r_cached, n_cached;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [HANDLE_W-1:0] r_rh, n_rh;
    logic                r_ev, n_ev;
    logic [HANDLE_W-1:0] r_evh, n_evh;
    logic                r_fr, n_fr;
    logic [HANDLE_W-1:0] r_frh, n_frh;

    logic                ofs_we;
    logic [PW-1:0]       ofs_waddr, ofs_raddr;
    logic [OFFSET_W-1:0] ofs_rdata;
    logic                refs_we;
    logic [PW-1:0]       refs_waddr, refs_raddr;
    logic [REFS_W-1:0]   refs_wdata, refs_rdata;
    logic                ring_we;
    logic [SW-1:0]       ring_waddr, ring_raddr;
    logic [PW-1:0]       ring_wdata, ring_rdata;

    logic [PW-1:0]       in_h;
    logic                in_good;
    logic                issue;
    logic [31:0]         lim;
    logic                evict_cond;
    logic [REFS_W-1:0]   dec_val;

    function automatic logic [SW-1:0] slot_at(input logic [SW-1:0] base,
                                              input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(pos);
        if (s >= (CW+1)'(CACHE_SLOTS)) begin
            s = s - (CW+1)'(CACHE_SLOTS);
        end
        return SW'(s);
    endfunction

    refc_ram #(.WIDTH(OFFSET_W), .DEPTH(POOL_ENTRIES), .AW(PW)) u_ofs_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ofs_we),
        .i_wr_addr(ofs_waddr),
        .i_wr_data(r_tag),
        .i_rd_addr(ofs_raddr),
        .o_rd_data(ofs_rdata)
    );

    refc_ram #(.WIDTH(REFS_W), .DEPTH(POOL_ENTRIES), .AW(PW)) u_refs_ram (
        .i_clk    (i_clk),
        .i_wr_en  (refs_we),
        .i_wr_addr(refs_waddr),
        .i_wr_data(refs_wdata),
        .i_rd_addr(refs_raddr),
        .o_rd_data(refs_rdata)
    );

    refc_ram #(.WIDTH(PW), .DEPTH(CACHE_SLOTS), .AW(SW)) u_ring_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ring_we),
        .i_wr_addr(ring_waddr),
        .i_wr_data(ring_wdata),
        .i_rd_addr(ring_raddr),
        .o_rd_data(ring_rdata)
    );

    assign in_h    = PW'(i_handle);
    assign in_good = !i_handle_null && (32'(i_handle) < POOL_ENTRIES) && r_live[in_h];
    assign issue   = (r_pos < r_count);
    assign dec_val = (refs_rdata != '0) ? (refs_rdata - 16'd1) : '0;

    always_comb begin
        if (r_max_cached == '0) begin
            lim = 32'd1;
        end else if (32'(r_max_cached) > CACHE_SLOTS) begin
            lim = CACHE_SLOTS;
        end else begin
            lim = 32'(r_max_cached);
        end
    end
    assign evict_cond = (32'(r_count) >= lim) && (r_count != '0);

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_tag        = r_tag;
        n_h          = r_h;
        n_tgt        = r_tgt;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_wpos       = r_wpos;
        n_s1pos      = r_s1pos;
        n_s1v        = r_s1v;
        n_s2v        = r_s2v;
        n_s2h        = r_s2h;
        n_ret_append = r_ret_append;
        n_head       = r_head;
        n_count      = r_count;
        n_live       = r_live;
        n_cached     = r_cached;
        n_status     = r_status;
        n_rh         = r_rh;
        n_ev         = r_ev;
        n_evh        = r_evh;
        n_fr         = r_fr;
        n_frh        = r_frh;

        ofs_we     = 1'b0;
        ofs_waddr  = r_idx;
        ofs_raddr  = r_h;
        refs_we    = 1'b0;
        refs_waddr = r_tgt;
        refs_wdata = refs_rdata;
        refs_raddr = r_tgt;
        ring_we    = 1'b0;
        ring_waddr = slot_at(r_head, r_wpos);
        ring_wdata = ring_rdata;
        ring_raddr = slot_at(r_head, r_pos);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode   = i_mode;
                    n_tag    = i_offset;
                    n_h      = in_h;
                    n_status = ST_OK;
                    n_rh     = '0;
                    n_ev     = 1'b0;
                    n_evh    = '0;
                    n_fr     = 1'b0;
                    n_frh    = '0;
                    n_pos    = '0;
                    n_s1v    = 1'b0;
                    n_s2v    = 1'b0;
                    case (i_mode)
                        MODE_ALLOC: begin
                            n_idx   = '0;
                            n_state = S_ALLOC;
                        end
                        MODE_FIND: begin
                            n_state = S_LOOK;
                        end
                        MODE_COMMIT: begin
                            if (!in_good) begin
                                n_status = ST_BAD_HDL;
                                n_state  = S_DONE;
                            end else if (r_cached[in_h]) begin
                                n_status = ST_IS_CACHED;
                                n_state  = S_DONE;
                            end else begin
                                ofs_raddr = in_h;
                                n_state   = S_OFS;
                            end
                        end
                        default: begin
                            if (i_handle_null) begin
                                n_state = S_DONE;
                            end else if (!in_good) begin
                                n_status = ST_BAD_HDL;
                                n_state  = S_DONE;
                            end else begin
                                refs_raddr   = in_h;
                                n_tgt        = in_h;
                                n_ret_append = 1'b0;
                                n_state      = S_DEC;
                            end
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (!r_live[r_idx]) begin
                    n_live[r_idx]   = 1'b1;
                    n_cached[r_idx] = 1'b0;
                    refs_we    = 1'b1;
                    refs_waddr = r_idx;
                    refs_wdata = 16'd1;
                    ofs_we     = 1'b1;
                    n_rh       = HANDLE_W'(r_idx);
                    n_state    = S_DONE;
                end else if (r_idx == PW'(POOL_ENTRIES - 1)) begin
                    n_status = ST_NO_FREE;
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_OFS: begin
                n_tag   = ofs_rdata;
                n_state = S_LOOK;
            end
            S_LOOK: begin
                // three-deep scan: ring slot -> record handle -> offset compare
                if (!issue) begin
                    ring_raddr = r_head;
                end
                n_s1v     = issue;
                if (issue) begin
                    n_pos = r_pos + 1'b1;
                end
                ofs_raddr = ring_rdata;
                n_s2v     = r_s1v;
                n_s2h     = ring_rdata;
                if (r_s2v && (ofs_rdata == r_tag)) begin
                    n_s1v      = 1'b0;
                    n_s2v      = 1'b0;
                    refs_raddr = r_s2h;
                    n_tgt      = r_s2h;
                    n_state    = (r_mode == MODE_FIND) ? S_INC : S_DUP;
                end else if (!issue && !r_s1v && !r_s2v) begin
                    if (r_mode == MODE_FIND) begin
                        n_status = ST_MISS;
                        n_state  = S_DONE;
                    end else if (evict_cond) begin
                        n_state = S_EVICT;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_INC: begin
                refs_we = 1'b1;
                if (refs_rdata != REFS_MAX) begin
                    refs_wdata = refs_rdata + 16'd1;
                end
                n_rh    = HANDLE_W'(r_tgt);
                n_state = S_DONE;
            end
            S_DUP: begin
                // twin gets +1 then -1: only a saturated count moves
                refs_we = 1'b1;
                if (refs_rdata == REFS_MAX) begin
                    refs_wdata = REFS_MAX - 16'd1;
                end
                refs_raddr   = r_h;
                n_tgt        = r_h;
                n_ret_append = 1'b0;
                n_state      = S_DEC;
            end
            S_EVICT: begin
                n_head            = slot_at(r_head, CW'(1));
                n_count           = r_count - 1'b1;
                n_ev              = 1'b1;
                n_evh             = HANDLE_W'(ring_rdata);
                n_cached[ring_rdata] = 1'b0;
                refs_raddr        = ring_rdata;
                n_tgt             = ring_rdata;
                n_ret_append      = 1'b1;
                n_state           = S_DEC;
            end
            S_DEC: begin
                refs_we    = 1'b1;
                refs_wdata = dec_val;
                n_state    = r_ret_append ? S_APPEND : S_DONE;
                if (dec_val == '0) begin
                    n_live[r_tgt] = 1'b0;
                    n_fr          = 1'b1;
                    n_frh         = HANDLE_W'(r_tgt);
                    if (r_cached[r_tgt]) begin
                        n_cached[r_tgt] = 1'b0;
                        n_pos   = '0;
                        n_s1v   = 1'b0;
                        n_state = S_RMSCAN;
                    end
                end
            end
            S_APPEND: begin
                if (32'(r_count) < CACHE_SLOTS) begin
                    ring_we     = 1'b1;
                    ring_waddr  = slot_at(r_head, r_count);
                    ring_wdata  = r_h;
                    n_count     = r_count + 1'b1;
                    n_cached[r_h] = 1'b1;
                end
                n_state = S_DONE;
            end
            S_RMSCAN: begin
                n_s1v = issue;
                if (issue) begin
                    n_pos   = r_pos + 1'b1;
                    n_s1pos = r_pos;
                end
                if (r_s1v && (ring_rdata == r_tgt)) begin
                    n_wpos  = r_s1pos;
                    n_pos   = r_s1pos + 1'b1;
                    n_s1v   = 1'b0;
                    n_state = S_SHIFT;
                end else if (!issue && !r_s1v) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // close the gap: each later entry moves one place toward head
                n_s1v = issue;
                if (issue) begin
                    n_pos = r_pos + 1'b1;
                end
                if (r_s1v) begin
                    ring_we = 1'b1;
                    n_wpos  = r_wpos + 1'b1;
                end
                if (!issue && !r_s1v) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_live       <= '0;
            r_cached     <= '0;
            r_max_cached <= MAX_CACHED_RESET;
            r_s1v        <= 1'b0;
            r_s2v        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_live   <= n_live;
            r_cached <= n_cached;
            r_s1v    <= n_s1v;
            r_s2v    <= n_s2v;
            if (i_cfg_wr_en) begin
                r_max_cached <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_tag        <= n_tag;
        r_h          <= n_h;
        r_tgt        <= n_tgt;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_wpos       <= n_wpos;
        r_s1pos      <= n_s1pos;
        r_s2h        <= n_s2h;
        r_ret_append <= n_ret_append;
        r_status     <= n_status;
        r_rh         <= n_rh;
        r_ev         <= n_ev;
        r_evh        <= n_evh;
        r_fr         <= n_fr;
        r_frh        <= n_frh;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_DONE);
    assign o_status         = r_status;
    assign o_result_handle  = r_rh;
    assign o_evicted_valid  = r_ev;
    assign o_evicted_handle = r_evh;
    assign o_freed_valid    = r_fr;
    assign o_freed_handle   = r_frh;

    `RFTC_ASSERT(a_strobe_single, i_clk, i_rst_n, o_valid |=> !o_valid && !busy, "result strobe longer than one cycle")
    `RFTC_ASSERT(a_start_takes, i_clk, i_rst_n, start && !busy |=> busy, "accepted command did not raise busy")
    `RFTC_ASSERT(a_count_bound, i_clk, i_rst_n, 32'(r_count) <= CACHE_SLOTS, "cache count above slot count")
    `RFTC_ASSERT(a_evict_ok, i_clk, i_rst_n, o_valid && o_evicted_valid |-> o_status == ST_OK && r_mode == MODE_COMMIT, "eviction outside a good commit")
    `RFTC_ASSERT(a_freed_ok, i_clk, i_rst_n, o_valid && o_freed_valid |-> o_status == ST_OK, "record freed on a failed command")

endmodule
